### hdl/tsic_pkg.sv
package tsic_pkg;

   localparam int CAPTURE_BITS   = 24;
   localparam int SPEED_BITS     = 28;
   localparam int ERR_BITS       = 29;
   localparam int DUTY_BITS      = 16;
   localparam int ACC_BITS       = 17;
   localparam int GAIN_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int GAIN_DIVISOR   = 64;
   localparam int GAIN_SHIFT     = $clog2(GAIN_DIVISOR);
   localparam int PROD_BITS      = GAIN_BITS + 1 + ERR_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int STEP_BITS      = $clog2(SPEED_BITS);

   localparam logic [SPEED_BITS-1:0] SPEED_NUMERATOR = SPEED_BITS'(200000000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND    = CSR_INDEX_BITS'(4);

   localparam logic [15:0]          RESET_TARGET  = 16'd0;
   localparam logic [GAIN_BITS-1:0] RESET_GAIN    = GAIN_BITS'(20);
   localparam logic [15:0]          RESET_FLOOR   = 16'd15000;
   localparam logic [15:0]          RESET_CEILING = 16'd39900;
   localparam logic [15:0]          RESET_BAND    = 16'd100;

   typedef struct packed {
      logic [15:0]          setpoint;
      logic [GAIN_BITS-1:0] integral_gain;
      logic [15:0]          duty_floor;
      logic [15:0]          duty_ceiling;
      logic [15:0]          reject_band;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic [CAPTURE_BITS-1:0] period;
   } push_type;

   typedef struct packed {
      logic                    full;
      logic                    not_empty;
      logic [CAPTURE_BITS-1:0] period;
   } q_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_MULT,
      ST_SUM,
      ST_OUT
   } back_state_type;

endpackage

### hdl/tsic_req_if.sv
interface tsic_req_if;
   import tsic_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CAPTURE_BITS-1:0] capture_time;
   modport source (output valid, output capture_time, input ready);
   modport sink (input valid, input capture_time, output ready);
endinterface

### hdl/tsic_rsp_if.sv
interface tsic_rsp_if;
   import tsic_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [DUTY_BITS-1:0]       duty;
   logic [SPEED_BITS-1:0]      speed_out;
   logic signed [ERR_BITS-1:0] speed_error;
   modport source (output valid, output duty, output speed_out, output speed_error,
                   input ready);
   modport sink (input valid, input duty, input speed_out, input speed_error,
                 output ready);
endinterface

### hdl/tsic_csr_if.sv
interface tsic_csr_if;
   import tsic_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/tsic_front.sv
module tsic_front (
   input  logic                 clock,
   input  logic                 reset,
   tsic_req_if.sink             req,
   input  tsic_pkg::q_stat_type q_stat,
   output tsic_pkg::push_type   push
);
   import tsic_pkg::*;

   logic [CAPTURE_BITS-1:0] last_capture_ff;
   logic [CAPTURE_BITS-1:0] last_capture_in;
   logic [CAPTURE_BITS-1:0] period;
   logic                    take;

   assign req.ready = !q_stat.full;
   assign take      = req.valid && req.ready;
   // down-counting timer: older stamp minus newer, wrapping
   assign period    = last_capture_ff - req.capture_time;

   always_comb begin
      last_capture_in = take ? req.capture_time : last_capture_ff;
   end

   // drop zero periods here, queue the rest
   assign push.valid  = take && (period != '0);
   assign push.period = period;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_capture_ff <= '0;
      end else begin
         last_capture_ff <= last_capture_in;
      end
   end

endmodule

### hdl/tsic_queue.sv
module tsic_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  tsic_pkg::push_type   push,
   input  logic                 pop,
   output tsic_pkg::q_stat_type q_stat
);
   import tsic_pkg::*;

   logic [CAPTURE_BITS-1:0]   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign q_stat.full      = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.period    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/tsic_back.sv
module tsic_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tsic_pkg::cfg_type    cfg,
   input  tsic_pkg::q_stat_type q_stat,
   output logic                 pop,
   tsic_rsp_if.source           rsp
);
   import tsic_pkg::*;

   back_state_type state_ff, state_in;

   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic [CAPTURE_BITS-1:0]     divisor_ff, divisor_in;
   logic [CAPTURE_BITS-1:0]     rem_ff, rem_in;
   logic [SPEED_BITS-1:0]       quot_ff, quot_in;
   logic [SPEED_BITS-1:0]       held_ff, held_in;
   logic [ERR_BITS-1:0]         err_ff, err_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [PROD_BITS-1:0] sum_ff, sum_in;
   logic [ACC_BITS-1:0]         duty_acc_ff, duty_acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]        duty_ff, duty_in;
   logic [SPEED_BITS-1:0]       speed_ff, speed_in;
   logic [ERR_BITS-1:0]         error_ff, error_in;

   logic load_div, div_step, check_en, mult_en, sum_en, out_en;
   logic div_last, out_free, reject;

   logic [CAPTURE_BITS:0]       trial, diff;
   logic                        ge;
   logic [SPEED_BITS:0]         upper;
   logic [SPEED_BITS-1:0]       lower;
   logic signed [PROD_BITS-1:0] bias, adj, scaled;
   logic signed [PROD_BITS-1:0] floor_ext, ceil_ext, lo_clamp, clamped;

   assign div_last = (step_ff == STEP_BITS'(SPEED_BITS - 1));
   assign out_free = !rsp_valid_ff || rsp.ready;

   // band test against the held speed; lower bound clamps at zero
   always_comb begin
      upper  = (SPEED_BITS + 1)'(held_ff) + (SPEED_BITS + 1)'(cfg.reject_band);
      lower  = (held_ff >= SPEED_BITS'(cfg.reject_band)) ?
               held_ff - SPEED_BITS'(cfg.reject_band) : '0;
      reject = (held_ff != '0) &&
               (((SPEED_BITS + 1)'(quot_ff) >= upper) || (quot_ff <= lower));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_stat.not_empty) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_last) state_in = ST_CHECK;
         ST_CHECK:  state_in = reject ? ST_IDLE : ST_MULT;
         ST_MULT:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = 1'b0;
      load_div = 1'b0;
      div_step = 1'b0;
      check_en = 1'b0;
      mult_en  = 1'b0;
      sum_en   = 1'b0;
      out_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop      = q_stat.not_empty;
            load_div = q_stat.not_empty;
         end
         ST_DIVIDE: div_step = 1'b1;
         ST_CHECK:  check_en = !reject;
         ST_MULT:   mult_en  = 1'b1;
         ST_SUM:    sum_en   = 1'b1;
         ST_OUT:    out_en   = out_free;
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, quot_ff[SPEED_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      if (load_div) begin
         step_in    = '0;
         divisor_in = q_stat.period;
         rem_in     = '0;
         quot_in    = SPEED_NUMERATOR;
      end else if (div_step) begin
         step_in = step_ff + 1'b1;
         rem_in  = ge ? diff[CAPTURE_BITS-1:0] : trial[CAPTURE_BITS-1:0];
         quot_in = {quot_ff[SPEED_BITS-2:0], ge};
      end
   end

   always_comb begin
      held_in = check_en ? quot_ff : held_ff;
      err_in  = check_en ? ERR_BITS'(cfg.setpoint) - ERR_BITS'(quot_ff) : err_ff;
      prod_in = mult_en ? $signed({1'b0, cfg.integral_gain}) * $signed(err_ff) : prod_ff;
   end

   // scale toward zero, then add the integrator
   always_comb begin
      bias   = prod_ff[PROD_BITS-1] ? PROD_BITS'(GAIN_DIVISOR - 1) : '0;
      adj    = prod_ff + bias;
      scaled = adj >>> GAIN_SHIFT;
      sum_in = sum_en ? scaled + $signed(PROD_BITS'(duty_acc_ff)) : sum_ff;
   end

   // floor first, ceiling after
   always_comb begin
      floor_ext = $signed(PROD_BITS'(cfg.duty_floor));
      ceil_ext  = $signed(PROD_BITS'(cfg.duty_ceiling));
      lo_clamp  = (sum_ff < floor_ext) ? floor_ext : sum_ff;
      clamped   = (lo_clamp > ceil_ext) ? ceil_ext : lo_clamp;
   end

   always_comb begin
      duty_acc_in  = duty_acc_ff;
      duty_in      = duty_ff;
      speed_in     = speed_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (out_en) begin
         duty_acc_in  = ACC_BITS'(clamped);
         duty_in      = clamped[DUTY_BITS-1:0];
         speed_in     = held_ff;
         error_in     = err_ff;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.duty        = duty_ff;
   assign rsp.speed_out   = speed_ff;
   assign rsp.speed_error = $signed(error_ff);

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      err_ff     <= err_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      duty_ff    <= duty_in;
      speed_ff   <= speed_in;
      error_ff   <= error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         held_ff      <= '0;
         duty_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         duty_acc_ff  <= duty_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/tach_speed_integral_control.sv
// Tachometer speed measurement with an integral duty controller.
// req carries one capture_time word per tachometer edge, latched from a
// down-counting 24-bit timer. The front end turns it into a period against
// the previous capture (the first from zero), drops zero periods and queues
// the rest in a two-entry queue. The back end divides 200000000 by the
// period with a restoring divider, one quotient bit a cycle, tests the new
// speed against the held speed and the reject band, then updates the duty
// integrator and offers duty, speed_out and speed_error on rsp. A rejected
// sample produces no rsp word.
// The back end works on one sample at a time: pop, the 28 divider steps,
// band check, multiply, sum and output; it pops the next only after the
// output step, or after the band check for a rejected sample.
// csr is always ready; write registers only while no sample is in flight.
// Reset (synchronous) clears the last capture, held speed and integrator
// and loads the register defaults. A stalled rsp holds its word; the back
// end waits in its output step while the queue goes on taking req words
// until full, when req.ready drops.
module tach_speed_integral_control (
   input logic        clock,
   input logic        reset,
   tsic_req_if.sink   req,
   tsic_rsp_if.source rsp,
   tsic_csr_if.sink   csr
);
   import tsic_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   push_type   push;
   q_stat_type q_stat;
   logic       pop;

   // registers take every word; unknown indexes are dropped
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_TARGET:  cfg_in.setpoint      = csr.data;
            CSR_GAIN:    cfg_in.integral_gain = csr.data[GAIN_BITS-1:0];
            CSR_FLOOR:   cfg_in.duty_floor    = csr.data;
            CSR_CEILING: cfg_in.duty_ceiling  = csr.data;
            CSR_BAND:    cfg_in.reject_band   = csr.data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint      <= RESET_TARGET;
         cfg_ff.integral_gain <= RESET_GAIN;
         cfg_ff.duty_floor    <= RESET_FLOOR;
         cfg_ff.duty_ceiling  <= RESET_CEILING;
         cfg_ff.reject_band   <= RESET_BAND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: period and zero-period filter
   tsic_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_stat (q_stat),
      .push   (push)
   );

   // decoupling queue between front and back
   tsic_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .q_stat (q_stat)
   );

   // back end: divider, band test, integrator, output register
   tsic_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp    (rsp)
   );

   // a queued period is visible to the back end on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push.valid |=> q_stat.not_empty)
      else $error("queued period lost");

   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_stat.full)
      else $error("push into full queue");

   // any delivered speed comes from a nonzero period below 2^24
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.speed_out != '0) && (rsp.speed_out <= SPEED_NUMERATOR))
      else $error("speed out of range");

endmodule
